// File: hw/rtl/sgcrm_pkg.sv
// Shared types, constants and the gain/saturate function for the stereo gain and RMS meter.
`timescale 1ns / 1ps
`default_nettype none

package sgcrm_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int GAIN_W        = 16;
	localparam int ROOT_W        = 16;
	localparam int MEAN_W        = 2 * ROOT_W;
	localparam int MAX_BLOCK_DEF = 512;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_ACC,
		ST_DIV,
		ST_SQLD,
		ST_SQRT,
		ST_OUT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic cap_in;
		logic gain_en;
		logic acc_en;
		logic div_start;
		logic div_step;
		logic sqrt_start;
		logic sqrt_step;
		logic out_load;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic close;
		logic div_last;
		logic sqrt_last;
		logic out_free;
	} sts_t;

	// Sample times Q8.8 gain, floor shift by 8, saturate to 16 bits
	function automatic logic signed [SAMPLE_W-1:0] gain_sat(
		input logic signed [SAMPLE_W-1:0] s,
		input logic [GAIN_W-1:0] g
	);
		logic signed [GAIN_W:0]              g_s;
		logic signed [SAMPLE_W+GAIN_W:0]     prod;
		logic signed [SAMPLE_W+GAIN_W:0]     shr;
		logic signed [SAMPLE_W-1:0]          res;
		g_s  = $signed({1'b0, g});
		prod = s * g_s;
		shr  = prod >>> 8;
		if (shr > 33'sd32767) begin
			res = 16'sh7FFF;
		end else if (shr < -33'sd32768) begin
			res = 16'sh8000;
		end else begin
			res = shr[SAMPLE_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stereo_gain_clip_rms_meter.sv
// Top level: stereo saturating gain with block RMS meter.
// After accept, a pair passes the gain, accumulate and output states before its output word is valid.
// A closing pair also runs the divider (SUM_W = 32 + clog2(MAX_BLOCK) quotient steps), one root
// load state and 16 root steps before the output state.
// A new pair is taken only after the last one's output word is loaded; a held output word stalls it.
// Reset (arst_n low, async): gain 256, sums and pair count cleared, no output word pending.
`timescale 1ns / 1ps
`default_nettype none

module stereo_gain_clip_rms_meter import sgcrm_pkg::*; #(
	parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [GAIN_W-1:0]          gain_q8_8,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] left_in,
	input  wire logic signed [SAMPLE_W-1:0] right_in,
	input  wire logic                       block_end,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      left_out,
	output logic signed [SAMPLE_W-1:0]      right_out,
	output logic                            rms_valid,
	output logic [ROOT_W-1:0]               rms_level
);

	cmd_t cmd;
	sts_t sts;

	// Gain register takes a write in any cycle
	assign cfg_ready = 1'b1;

	sgcrm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sgcrm_dp #(
		.MAX_BLOCK(MAX_BLOCK)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.gain_q8_8(gain_q8_8),
		.left_in  (left_in),
		.right_in (right_in),
		.block_end(block_end),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.left_out (left_out),
		.right_out(right_out),
		.rms_valid(rms_valid),
		.rms_level(rms_level)
	);

endmodule

`default_nettype wire

// File: hw/rtl/sgcrm_meas.sv
// One channel's level unit: restoring divider for the mean square, then bit-serial square root.
`timescale 1ns / 1ps
`default_nettype none

module sgcrm_meas import sgcrm_pkg::*; #(
	parameter int SUM_W = 41,
	parameter int CNT_W = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire logic [SUM_W-1:0] dividend,
	input  wire logic [CNT_W-1:0] divisor,
	output logic [ROOT_W-1:0]     root
);

	logic [SUM_W-1:0]    dvd_q;
	logic [CNT_W-1:0]    div_q;
	logic [CNT_W-1:0]    rem_q;
	logic [CNT_W:0]      rem_sh;
	logic                div_ge;
	logic [CNT_W:0]      rem_sub;

	logic [MEAN_W-1:0]   rad_q;
	logic [ROOT_W+1:0]   srem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [ROOT_W+3:0]   srem_sh;
	logic [ROOT_W+3:0]   trial;
	logic                sq_ge;
	logic [ROOT_W+3:0]   srem_sub;

	// Divider step: one quotient bit per cycle, quotient shifts into dvd_q
	always_comb begin
		rem_sh  = {rem_q, dvd_q[SUM_W-1]};
		div_ge  = rem_sh >= {1'b0, div_q};
		rem_sub = rem_sh - {1'b0, div_q};
	end

	// Root step: two radicand bits in, one root bit out per cycle
	always_comb begin
		srem_sh  = {srem_q, rad_q[MEAN_W-1 -: 2]};
		trial    = {2'b00, root_q, 2'b01};
		sq_ge    = srem_sh >= trial;
		srem_sub = srem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
			rad_q  <= '0;
			srem_q <= '0;
			root_q <= '0;
		end else begin
			if (cmd.div_start) begin
				dvd_q <= dividend;
				div_q <= divisor;
				rem_q <= '0;
			end else if (cmd.div_step) begin
				dvd_q <= {dvd_q[SUM_W-2:0], div_ge};
				rem_q <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			end
			if (cmd.sqrt_start) begin
				rad_q  <= dvd_q[MEAN_W-1:0];
				srem_q <= '0;
				root_q <= '0;
			end else if (cmd.sqrt_step) begin
				rad_q  <= {rad_q[MEAN_W-3:0], 2'b00};
				srem_q <= sq_ge ? srem_sub[ROOT_W+1:0] : srem_sh[ROOT_W+1:0];
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
			end
		end
	end

	assign root = root_q;

endmodule

`default_nettype wire

// File: hw/rtl/sgcrm_dp.sv
// Datapath: gain register, sample capture, gain and saturation, square sums, level units, output word.
`timescale 1ns / 1ps
`default_nettype none

module sgcrm_dp import sgcrm_pkg::*; #(
	parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	input  wire logic [GAIN_W-1:0]          gain_q8_8,
	input  wire logic signed [SAMPLE_W-1:0] left_in,
	input  wire logic signed [SAMPLE_W-1:0] right_in,
	input  wire logic                       block_end,
	input  wire cmd_t                       cmd,
	output sts_t                            sts,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      left_out,
	output logic signed [SAMPLE_W-1:0]      right_out,
	output logic                            rms_valid,
	output logic [ROOT_W-1:0]               rms_level
);

	localparam int SUM_W  = MEAN_W + $clog2(MAX_BLOCK);
	localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
	localparam int ITER_W = $clog2(SUM_W);

	logic [GAIN_W-1:0]          gain_q;
	logic signed [SAMPLE_W-1:0] lin_q, rin_q;
	logic                       end_q;
	logic signed [SAMPLE_W-1:0] lg_q, rg_q;
	logic [SUM_W-1:0]           lsum_q, rsum_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       rms_q;
	logic [ITER_W-1:0]          iter_q;

	logic [MEAN_W-1:0]          lsq, rsq;
	logic [SUM_W-1:0]           lsum_nx, rsum_nx;
	logic [CNT_W-1:0]           cnt_nx;
	logic                       close;
	logic [ROOT_W-1:0]          lroot, rroot;
	logic [ROOT_W:0]            root_sum;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] left_out_q, right_out_q;
	logic                       rms_valid_q;
	logic [ROOT_W-1:0]          rms_level_q;

	// Gain register, written from the config channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_valid) begin
			gain_q <= gain_q8_8;
		end
	end

	// Input capture and gained samples
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			lin_q <= left_in;
			rin_q <= right_in;
			end_q <= block_end;
		end
		if (cmd.gain_en) begin
			lg_q <= gain_sat(lin_q, gain_q);
			rg_q <= gain_sat(rin_q, gain_q);
		end
	end

	// Squares, running sums and block close
	always_comb begin
		lsq     = $unsigned(MEAN_W'(lg_q) * MEAN_W'(lg_q));
		rsq     = $unsigned(MEAN_W'(rg_q) * MEAN_W'(rg_q));
		lsum_nx = lsum_q + SUM_W'(lsq);
		rsum_nx = rsum_q + SUM_W'(rsq);
		cnt_nx  = cnt_q + CNT_W'(1);
		close   = end_q || (cnt_nx == CNT_W'(MAX_BLOCK));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_q <= '0;
			rsum_q <= '0;
			cnt_q  <= '0;
			rms_q  <= 1'b0;
		end else if (cmd.acc_en) begin
			lsum_q <= close ? '0 : lsum_nx;
			rsum_q <= close ? '0 : rsum_nx;
			cnt_q  <= close ? '0 : cnt_nx;
			rms_q  <= close;
		end
	end

	// Shared step counter for divide and root passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.div_start || cmd.sqrt_start) begin
			iter_q <= '0;
		end else if (cmd.div_step || cmd.sqrt_step) begin
			iter_q <= iter_q + ITER_W'(1);
		end
	end

	// Per-channel level units
	sgcrm_meas #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_meas_l (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.dividend(lsum_nx),
		.divisor (cnt_nx),
		.root    (lroot)
	);

	sgcrm_meas #(
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_meas_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.dividend(rsum_nx),
		.divisor (cnt_nx),
		.root    (rroot)
	);

	assign root_sum = {1'b0, lroot} + {1'b0, rroot};

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			left_out_q  <= lg_q;
			right_out_q <= rg_q;
			rms_valid_q <= rms_q;
			rms_level_q <= rms_q ? root_sum[ROOT_W:1] : '0;
		end
	end

	// Status to controller
	always_comb begin
		sts.close     = close;
		sts.div_last  = iter_q == ITER_W'(SUM_W - 1);
		sts.sqrt_last = iter_q == ITER_W'(ROOT_W - 1);
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;
	assign rms_valid = rms_valid_q;
	assign rms_level = rms_level_q;

endmodule

`default_nettype wire

// File: hw/rtl/sgcrm_ctrl.sv
// Controller state machine: sequences capture, gain, accumulate, divide, root and output.
`timescale 1ns / 1ps
`default_nettype none

module sgcrm_ctrl import sgcrm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_GAIN;
			ST_GAIN: state_nx = ST_ACC;
			ST_ACC:  state_nx = sts.close ? ST_DIV : ST_OUT;
			ST_DIV:  if (sts.div_last) state_nx = ST_SQLD;
			ST_SQLD: state_nx = ST_SQRT;
			ST_SQRT: if (sts.sqrt_last) state_nx = ST_OUT;
			ST_OUT:  if (sts.out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.cap_in = in_valid;
			end
			ST_GAIN: cmd.gain_en = 1'b1;
			ST_ACC: begin
				cmd.acc_en    = 1'b1;
				cmd.div_start = sts.close;
			end
			ST_DIV:  cmd.div_step   = 1'b1;
			ST_SQLD: cmd.sqrt_start = 1'b1;
			ST_SQRT: cmd.sqrt_step  = 1'b1;
			ST_OUT:  cmd.out_load   = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: tb/sv/tb_stereo_gain_clip_rms_meter.sv
// Self-checking testbench for the stereo saturating gain and block RMS meter.
`timescale 1ns / 1ps

module tb_stereo_gain_clip_rms_meter;
	import sgcrm_pkg::*;

	localparam int BLOCK_LIMIT    = MAX_BLOCK_DEF;
	localparam int DRAIN_PAD      = 80;     // margin for the divide and root passes of a closing pair
	localparam int LONG_HOLD      = 300;    // receiver back-pressure stretch
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 165;
	localparam int PHASES         = 8;
	localparam int REPORT_MAX     = 10;

	// One output word of the meter
	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       rms_on;
		logic [ROOT_W-1:0]          level;
	} meter_word_t;

	// One row of the directed table; gain < 0 keeps the current gain
	typedef struct {
		int          gain;
		int          count;
		int          left;
		int          right;
		bit          last;
		bit          typed;
		meter_word_t word;
	} pair_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [GAIN_W-1:0]          cfg_gain = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] left_in = '0;
	logic signed [SAMPLE_W-1:0] right_in = '0;
	logic                       block_end = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic                       rms_valid;
	logic [ROOT_W-1:0]          rms_level;

	// Predictor state
	logic [GAIN_W-1:0] gain_reg;
	longint unsigned   left_energy;
	longint unsigned   right_energy;
	int                pairs_open;

	meter_word_t expected_words[$];
	int          mismatches = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          hold_requests = 0;
	int          hold_granted = 0;
	int          hold_left = 0;
	int          idle_cycles = 0;
	int          blk_left = 0;
	pair_row_t   directed_rows[$];

	stereo_gain_clip_rms_meter #(.MAX_BLOCK(BLOCK_LIMIT)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.gain_q8_8 (cfg_gain),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.left_in   (left_in),
		.right_in  (right_in),
		.block_end (block_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.left_out  (left_out),
		.right_out (right_out),
		.rms_valid (rms_valid),
		.rms_level (rms_level)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sample times Q8.8 gain, floor by 8 bits, clamp to 16-bit range
	function automatic logic signed [SAMPLE_W-1:0] scale_sample(
		input logic signed [SAMPLE_W-1:0] s,
		input logic [GAIN_W-1:0] g
	);
		longint p;
		p = (longint'(s) * longint'(g)) >>> 8;
		if (p > 32767)
			p = 32767;
		else if (p < -32768)
			p = -32768;
		return p[SAMPLE_W-1:0];
	endfunction

	// Floor square root, one result bit per pass
	function automatic logic [ROOT_W:0] floor_root(input longint unsigned v);
		logic [ROOT_W:0] root;
		logic [ROOT_W:0] trial;
		root = '0;
		for (int b = ROOT_W; b >= 0; b--) begin
			trial = root | ((ROOT_W+1)'(1) << b);
			if (longint'(trial) * longint'(trial) <= v)
				root = trial;
		end
		return root;
	endfunction

	// Advance the meter state by one pair and give the word it produces
	function automatic meter_word_t predict_pair(
		input logic signed [SAMPLE_W-1:0] l,
		input logic signed [SAMPLE_W-1:0] r,
		input logic last
	);
		meter_word_t w;
		logic [ROOT_W+1:0] sum_root;
		w.left   = scale_sample(l, gain_reg);
		w.right  = scale_sample(r, gain_reg);
		w.rms_on = 1'b0;
		w.level  = '0;
		left_energy  += longint'(w.left) * longint'(w.left);
		right_energy += longint'(w.right) * longint'(w.right);
		pairs_open++;
		if (last || pairs_open >= BLOCK_LIMIT) begin
			sum_root = floor_root(left_energy / longint'(pairs_open))
				+ floor_root(right_energy / longint'(pairs_open));
			w.level      = sum_root[ROOT_W:1];
			w.rms_on     = 1'b1;
			left_energy  = 0;
			right_energy = 0;
			pairs_open   = 0;
		end
		return w;
	endfunction

	function automatic pair_row_t mk_row(int gain, int count, int l, int r, bit last,
		bit typed = 1'b0, int el = 0, int er = 0, bit ev = 1'b0, int lv = 0);
		pair_row_t row;
		row.gain        = gain;
		row.count       = count;
		row.left        = l;
		row.right       = r;
		row.last        = last;
		row.typed       = typed;
		row.word.left   = el[SAMPLE_W-1:0];
		row.word.right  = er[SAMPLE_W-1:0];
		row.word.rms_on = ev;
		row.word.level  = lv[ROOT_W-1:0];
		return row;
	endfunction

	// Append one row to the directed table
	task automatic add_row(input pair_row_t row);
		directed_rows.insert(directed_rows.size(), row);
	endtask

	// Append one word to the expected queue
	task automatic expect_word(input meter_word_t w);
		expected_words.insert(expected_words.size(), w);
	endtask

	// Mix of extremes, small values and full-range noise
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: case ($urandom_range(4))
				0: return 16'sh7FFF;
				1: return 16'sh8000;
				2: return 16'sh0000;
				3: return 16'shFFFF;
				default: return 16'sh0001;
			endcase
			1, 2: return SAMPLE_W'($urandom_range(600)) - 16'sd300;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Offer one input word, with random gaps, and hold it until taken
	task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
		input logic signed [SAMPLE_W-1:0] r, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		left_in   <= l;
		right_in  <= r;
		block_end <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	// Wait out every pending word and the tail of a closing pair
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_gain(input logic [GAIN_W-1:0] g);
		cfg_valid <= 1'b1;
		cfg_gain  <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gain_reg = g;
	endtask

	// Output side: check each accepted word, then choose ready for next cycle
	always @(posedge clk) begin
		meter_word_t want;
		if (out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: unexpected word L=%0d R=%0d v=%0b lvl=%0d", $realtime,
						left_out, right_out, rms_valid, rms_level);
			end else begin
				want = expected_words[0];
				expected_words.delete(0);
				if (left_out !== want.left || right_out !== want.right
						|| rms_valid !== want.rms_on || rms_level !== want.level) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: exp %0d %0d %0b %0d got %0d %0d %0b %0d",
							$realtime, want.left, want.right, want.rms_on, want.level,
							left_out, right_out, rms_valid, rms_level);
				end
			end
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_granted != hold_requests) begin
			hold_granted++;
			hold_left = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Watchdog: cycles without any accepted word
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		meter_word_t w;
		pair_row_t   row;
		int          g;
		logic        last;
		logic signed [SAMPLE_W-1:0] l;
		logic signed [SAMPLE_W-1:0] r;

		gain_reg     = GAIN_RESET;
		left_energy  = 0;
		right_energy = 0;
		pairs_open   = 0;

		// Directed table: reset gain, zero gain, full gain, tiny gain, clipping, full block
		add_row(mk_row(-1, 1, 32767, -32768, 1, 1, 32767, -32768, 1, 32767));
		add_row(mk_row(-1, 1, 0, 0, 1, 1, 0, 0, 1, 0));
		add_row(mk_row(-1, 1, -1, 1, 0));
		add_row(mk_row(-1, 1, 100, -100, 1));
		add_row(mk_row(0, 1, 32767, -32768, 1, 1, 0, 0, 1, 0));
		add_row(mk_row(-1, 1, -1, 12345, 0, 1, 0, 0, 0, 0));
		add_row(mk_row(-1, 1, 5, 5, 1, 1, 0, 0, 1, 0));
		add_row(mk_row(65535, 1, 32767, -32768, 1, 1, 32767, -32768, 1, 32767));
		add_row(mk_row(-1, 1, 1, -1, 0));
		add_row(mk_row(-1, 1, -1, -1, 1));
		add_row(mk_row(1, 1, -1, 1, 1));
		add_row(mk_row(-1, 1, -32768, 32767, 0));
		add_row(mk_row(-1, 1, 255, -255, 1));
		add_row(mk_row(512, 1, 20000, -20000, 1, 1, 32767, -32768, 1, 32767));
		add_row(mk_row(-1, 1, 16383, -16384, 0));
		add_row(mk_row(-1, 1, 0, 0, 1));
		// no block_end: the 512th pair closes the block on its own
		add_row(mk_row(300, BLOCK_LIMIT, 1000, -3000, 0));
		add_row(mk_row(-1, 3, -7, 9, 0));
		add_row(mk_row(-1, 1, -32768, -32768, 1));
		add_row(mk_row(256, 1, 21845, -21846, 1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.gain >= 0) begin
				drain();
				write_gain(row.gain[GAIN_W-1:0]);
			end
			for (int k = 0; k < row.count; k++) begin
				send_pair(row.left[SAMPLE_W-1:0], row.right[SAMPLE_W-1:0], row.last);
				w = predict_pair(row.left[SAMPLE_W-1:0], row.right[SAMPLE_W-1:0], row.last);
				if (row.typed)
					expect_word(row.word);
				else
					expect_word(w);
			end
		end

		// Random phases: each sets a gain and an idling pattern
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: g = 65535;
				1: g = $urandom_range(1023);
				2: g = 0;
				4: g = GAIN_RESET;
				5: g = $urandom_range(600, 128);
				6: g = 1;
				default: g = $urandom_range(65535);
			endcase
			write_gain(g[GAIN_W-1:0]);
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
				default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 4 && n == 40)
					hold_requests++;
				if (blk_left == 0) begin
					case ($urandom_range(99))
						0, 1: blk_left = $urandom_range(BLOCK_LIMIT + 20, BLOCK_LIMIT - 10);
						2, 3, 4, 5, 6, 7, 8, 9, 10, 11: blk_left = $urandom_range(120, 25);
						default: blk_left = $urandom_range(24, 1);
					endcase
				end
				last = (blk_left == 1);
				blk_left--;
				l = pick_sample();
				r = pick_sample();
				send_pair(l, r, last);
				w = predict_pair(l, r, last);
				expect_word(w);
			end
		end

		drain();
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
